/* rtl/core/scalar_kalman_smoother_defines.svh */
// Assertion macros used by the scalar Kalman smoother top module.
`ifndef SCALAR_KALMAN_SMOOTHER_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_DEFINES_SVH

// Check a property on every rising edge of clk_i outside reset.
`define SKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/skf_pkg.sv */
// Shared types and constants of the scalar Kalman smoother.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int NOISE_W         = 16;
  localparam int GAIN_W          = 16;
  localparam int CHAN_W          = 2;
  localparam int CFG_IDX_W       = 2;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 16'd1311;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST    = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_MEAS_NOISE    = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic force_max;
  } ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

`default_nettype wire

/* rtl/core/skf_if.sv */
// Valid/ready stream interfaces for samples in and estimates out.
`timescale 1ns / 1ps
`default_nettype none

interface skf_in_if #(
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_BITS-1:0]    sample;
  logic [skf_pkg::CHAN_W-1:0]       channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface skf_out_if #(
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_BITS-1:0]    estimate;
  logic [skf_pkg::CHAN_W-1:0]       channel_out;

  modport source (output valid, output estimate, output channel_out, input ready);
  modport sink   (input valid, input estimate, input channel_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/scalar_kalman_smoother.sv */
// Scalar Kalman smoother for up to CHANNELS interleaved sample streams, each with its own
// estimate and variance. From its input transfer an item passes LOAD, which reads the
// channel state and forms the predicted variance; DIV, in which a bit-serial restoring divider
// yields one gain bit a cycle while two shift-add accumulators build gain*(sample-old) and
// gain*predicted from those bits, until the divider reports done; and FIN, which updates the
// channel and loads the output register once that register is free. A sample for a channel
// past the last one skips DIV, returns a zero estimate and leaves all state alone. One item
// is in flight at a time; the next input is taken as soon as the result sits in the output
// register. Noise registers are to be written through the cfg port only while the block is
// idle; the user must see to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_kalman_smoother_defines.svh"

module scalar_kalman_smoother #(
  parameter int CHANNELS    = skf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [skf_pkg::NOISE_W-1:0]       cfg_data_i,
  skf_in_if.sink                                 in_i,
  skf_out_if.source                              out_o
);

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW     = skf_pkg::NOISE_W;
  localparam int GW     = skf_pkg::GAIN_W;
  localparam int PRED_W = NW + 1;
  localparam int DEN_W  = NW + 2;
  localparam int PD_W   = SAMPLE_BITS + 1 + GW;
  localparam int PP_W   = PRED_W + GW;

  skf_pkg::state_e                 state_q, state_d;
  logic [NW-1:0]                   pn_q, mn_q;
  logic signed [SAMPLE_BITS-1:0]   sample_q;
  logic [skf_pkg::CHAN_W-1:0]      chan_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_BITS-1:0]   out_est_q;
  logic [skf_pkg::CHAN_W-1:0]      out_chan_q;

  logic                            in_xfer, chan_ok, out_load, st_wr;
  logic [IDX_W-1:0]                idx;
  logic signed [SAMPLE_BITS-1:0]   rd_est;
  logic [NW-1:0]                   rd_var;
  logic [PRED_W-1:0]               pred, ser_pred;
  logic [DEN_W-1:0]                denom;
  logic signed [SAMPLE_BITS:0]     diff;
  logic signed [PD_W-1:0]          prod_diff;
  logic [PP_W-1:0]                 prod_pred;
  logic signed [SAMPLE_BITS+1:0]   est_sum;
  logic signed [SAMPLE_BITS-1:0]   new_est;
  logic [PP_W-1:0]                 var_diff;
  logic [PRED_W-1:0]               var_full;
  logic [NW-1:0]                   new_var;
  skf_pkg::ser_ctrl_t              ser_ctrl;
  skf_pkg::ser_stat_t              ser_stat;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == skf_pkg::ST_IDLE;
  assign chan_ok    = 32'(chan_q) < CHANNELS;
  assign idx        = IDX_W'(chan_q);

  // Noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= skf_pkg::PROCESS_NOISE_RST;
      mn_q <= skf_pkg::MEAS_NOISE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        skf_pkg::REG_PROCESS_NOISE: pn_q <= cfg_data_i;
        skf_pkg::REG_MEAS_NOISE:    mn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= in_i.sample;
      chan_q   <= in_i.channel;
    end
  end

  skf_store #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .idx_i    (idx),
    .wr_en_i  (st_wr),
    .wr_est_i (new_est),
    .wr_var_i (new_var),
    .rd_est_o (rd_est),
    .rd_var_o (rd_var)
  );

  // Predict the variance and form the divider and multiplier operands
  assign pred  = PRED_W'(rd_var) + PRED_W'(pn_q);
  assign denom = DEN_W'(pred) + DEN_W'(mn_q);
  assign diff  = (SAMPLE_BITS + 1)'(sample_q) - (SAMPLE_BITS + 1)'(rd_est);

  // Zero measurement noise pins the gain at its largest value
  assign ser_ctrl.start     = (state_q == skf_pkg::ST_LOAD) && chan_ok;
  assign ser_ctrl.force_max = mn_q == '0;

  skf_serial #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ser_ctrl),
    .pred_i      (pred),
    .denom_i     (denom),
    .diff_i      (diff),
    .stat_o      (ser_stat),
    .pred_o      (ser_pred),
    .prod_diff_o (prod_diff),
    .prod_pred_o (prod_pred)
  );

  // New estimate: old plus the floored product, always between old and sample
  assign est_sum = (SAMPLE_BITS + 2)'(rd_est)
                 + (SAMPLE_BITS + 2)'($signed(prod_diff[PD_W-1:GW]));
  assign new_est = $signed(est_sum[SAMPLE_BITS-1:0]);

  // New variance: (1 - gain) * predicted, truncated and capped
  assign var_diff = {ser_pred, {GW{1'b0}}} - prod_pred;
  assign var_full = var_diff[PP_W-1:GW];
  assign new_var  = var_full[PRED_W-1] ? {NW{1'b1}} : var_full[NW-1:0];

  assign out_load = (state_q == skf_pkg::ST_FIN) && (!out_valid_q || out_o.ready);
  assign st_wr    = out_load && chan_ok;

  // Sequence one item at a time
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skf_pkg::ST_IDLE: if (in_xfer) state_d = skf_pkg::ST_LOAD;
      skf_pkg::ST_LOAD: state_d = chan_ok ? skf_pkg::ST_DIV : skf_pkg::ST_FIN;
      skf_pkg::ST_DIV:  if (ser_stat.done) state_d = skf_pkg::ST_FIN;
      skf_pkg::ST_FIN:  if (out_load) state_d = skf_pkg::ST_IDLE;
      default:          state_d = skf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_est_q  <= chan_ok ? new_est : '0;
      out_chan_q <= chan_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.estimate    = out_est_q;
  assign out_o.channel_out = out_chan_q;

  `SKF_ASSERT(a_done_in_div, !ser_stat.done || (state_q == skf_pkg::ST_DIV),
              "serial unit finished outside the divide phase")
  `SKF_ASSERT(a_busy_in_div, !ser_stat.busy || (state_q == skf_pkg::ST_DIV),
              "serial unit busy outside the divide phase")
  `SKF_ASSERT(a_no_overwrite, !out_load || !out_valid_q || out_o.ready,
              "result loaded over a pending output")
  `SKF_ASSERT_NEXT(a_xfer_loads, in_xfer, state_q == skf_pkg::ST_LOAD,
                   "input transfer did not start the load phase")

endmodule

`default_nettype wire

/* rtl/core/skf_store.sv */
// Per-channel estimate and variance registers.
`timescale 1ns / 1ps
`default_nettype none

module skf_store #(
  parameter int CHANNELS    = skf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [IDX_W-1:0]                   idx_i,
  input  wire logic                               wr_en_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      wr_est_i,
  input  wire logic [skf_pkg::NOISE_W-1:0]        wr_var_i,
  output      logic signed [SAMPLE_BITS-1:0]      rd_est_o,
  output      logic [skf_pkg::NOISE_W-1:0]        rd_var_o
);

  logic signed [SAMPLE_BITS-1:0]     est_q [CHANNELS];
  logic [skf_pkg::NOISE_W-1:0]       var_q [CHANNELS];
  logic                              idx_ok;

  assign idx_ok = 32'(idx_i) < CHANNELS;

  // Read the selected channel; an index past the last channel reads zero
  always_comb begin
    rd_est_o = '0;
    rd_var_o = '0;
    if (idx_ok) begin
      rd_est_o = est_q[idx_i];
      rd_var_o = var_q[idx_i];
    end
  end

  // Update the selected channel at the end of an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est_q[i] <= '0;
        var_q[i] <= '0;
      end
    end else if (wr_en_i && idx_ok) begin
      est_q[idx_i] <= wr_est_i;
      var_q[idx_i] <= wr_var_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/skf_serial.sv */
// Bit-serial gain divider with two MSB-first shift-add multipliers fed by the quotient bits.
`timescale 1ns / 1ps
`default_nettype none

module skf_serial #(
  parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF,
  localparam int PRED_W     = skf_pkg::NOISE_W + 1,
  localparam int DEN_W      = skf_pkg::NOISE_W + 2,
  localparam int PD_W       = SAMPLE_BITS + 1 + skf_pkg::GAIN_W,
  localparam int PP_W       = PRED_W + skf_pkg::GAIN_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire skf_pkg::ser_ctrl_t           ctrl_i,
  input  wire logic [PRED_W-1:0]            pred_i,
  input  wire logic [DEN_W-1:0]             denom_i,
  input  wire logic signed [SAMPLE_BITS:0]  diff_i,
  output      skf_pkg::ser_stat_t           stat_o,
  output      logic [PRED_W-1:0]            pred_o,
  output      logic signed [PD_W-1:0]       prod_diff_o,
  output      logic [PP_W-1:0]              prod_pred_o
);

  localparam int REM_W  = DEN_W + 1;
  localparam int STEP_W = $clog2(skf_pkg::GAIN_W);

  logic [REM_W-1:0]            rem_q, rem_d, rem_sh, den_ext;
  logic [PRED_W-1:0]           pred_q;
  logic [DEN_W-1:0]            denom_q;
  logic signed [SAMPLE_BITS:0] diff_q;
  logic                        force_q;
  logic signed [PD_W-1:0]      accd_q, accd_d;
  logic [PP_W-1:0]             accp_q, accp_d;
  logic [STEP_W-1:0]           cnt_q;
  logic                        busy_q, done_q;
  logic                        ge, qbit, last;

  // One restoring division step yields the next gain bit, MSB first
  assign rem_sh  = {rem_q[REM_W-2:0], 1'b0};
  assign den_ext = {1'b0, denom_q};
  assign ge      = rem_sh >= den_ext;
  assign qbit    = force_q | ge;
  assign rem_d   = ge ? (rem_sh - den_ext) : rem_sh;

  // Fold the gain bit into both products
  assign accd_d = (accd_q <<< 1) + (qbit ? PD_W'(diff_q) : PD_W'(0));
  assign accp_d = {accp_q[PP_W-2:0], 1'b0} + (qbit ? PP_W'(pred_q) : PP_W'(0));

  assign last = cnt_q == STEP_W'(skf_pkg::GAIN_W - 1);

  // Step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q   <= REM_W'(pred_i);
      pred_q  <= pred_i;
      denom_q <= denom_i;
      diff_q  <= diff_i;
      force_q <= ctrl_i.force_max;
      accd_q  <= '0;
      accp_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      accd_q <= accd_d;
      accp_q <= accp_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign pred_o      = pred_q;
  assign prod_diff_o = accd_q;
  assign prod_pred_o = accp_q;

endmodule

`default_nettype wire

/* bench/tb_scalar_kalman_smoother.sv */
// Testbench for scalar_kalman_smoother: directed table plus random traffic, checked per channel.
`timescale 1ns / 1ps

module tb_scalar_kalman_smoother;

  localparam int STALL_LIMIT   = 2000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_SAMPLES = 75;
  localparam int SETTLE_CYCLES = 30;

  // Indexes past the last register; writes there must leave the noise values alone.
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [skf_pkg::CFG_IDX_W-1:0]     idx;
    logic [skf_pkg::NOISE_W-1:0]       value;
    logic [15:0]                       smp;
    logic [skf_pkg::CHAN_W-1:0]        chan;
    logic                              fixed;
    logic [15:0]                       fixed_est;
  } plan_row_t;

  typedef struct {
    logic signed [15:0]           est;
    logic [skf_pkg::CHAN_W-1:0]   chan;
  } est_entry_t;

  localparam int PLAN_ROWS = 29;

  // Directed walk: extremes after reset, zero and max noise, min noise, spare indexes.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0000, 2'd0, 1'b1, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0000, 2'd3, 1'b1, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd1, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd2, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0001, 2'd3, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'hFFFF, 2'd3, 1'b0, 16'h0000},
    // no noise at all: gain saturates, then the denominator hits zero
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  skf_pkg::REG_MEAS_NOISE,    16'h0000, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0005, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd2, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd2, 1'b0, 16'h0000},
    // largest noise values
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 16'hFFFF, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  skf_pkg::REG_MEAS_NOISE,    16'hFFFF, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd1, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd1, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h7FFF, 2'd2, 1'b0, 16'h0000},
    // smallest legal measurement noise
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  skf_pkg::REG_MEAS_NOISE,    16'h0001, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h8000, 2'd3, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h1234, 2'd3, 1'b0, 16'h0000},
    // writes to spare indexes are dropped
    '{ROW_WRITE,  REG_SPARE_A,                16'hFFFF, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_SPARE_B,                16'h5A5A, 16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, skf_pkg::REG_PROCESS_NOISE, 16'h0000, 16'h0100, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE, skf_pkg::PROCESS_NOISE_RST,
      16'h0000, 2'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  skf_pkg::REG_MEAS_NOISE,    skf_pkg::MEAS_NOISE_RST,
      16'h0000, 2'd0, 1'b0, 16'h0000}
  };

  logic                           clk_i;
  logic                           rst_n;
  logic                           cfg_we;
  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [skf_pkg::NOISE_W-1:0]    cfg_data;

  skf_in_if  #(.SAMPLE_BITS(skf_pkg::SAMPLE_BITS_DEF)) samples_if ();
  skf_out_if #(.SAMPLE_BITS(skf_pkg::SAMPLE_BITS_DEF)) estimates_if ();

  scalar_kalman_smoother uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (samples_if),
    .out_o      (estimates_if)
  );

  // Predictor state: per-channel estimate and variance plus the noise registers.
  logic signed [15:0]           chan_estimate [skf_pkg::CHANNELS_DEF];
  logic [15:0]                  chan_variance [skf_pkg::CHANNELS_DEF];
  logic [skf_pkg::NOISE_W-1:0]  process_noise_q;
  logic [skf_pkg::NOISE_W-1:0]  meas_noise_q;

  est_entry_t  estimate_q [$];
  int          err_count;
  bit          send_steady;
  bit          recv_steady;
  int          ready_hold;
  int          quiet_cycles;
  int unsigned hold_draw;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // One filter step for a channel; updates the predictor state and returns the new estimate.
  function automatic logic signed [15:0] kalman_update(
      input logic signed [15:0] smp, input logic [skf_pkg::CHAN_W-1:0] ch);
    longint pred;
    longint denom;
    longint gain;
    longint diff;
    longint est;
    longint var_next;
    if (int'(ch) >= skf_pkg::CHANNELS_DEF) return '0;
    pred  = longint'(chan_variance[ch]) + longint'(process_noise_q);
    denom = pred + longint'(meas_noise_q);
    if (denom == 0) begin
      gain = 65535;
    end else begin
      gain = (pred <<< 16) / denom;
      if (gain > 65535) gain = 65535;
    end
    diff = longint'(smp) - longint'(chan_estimate[ch]);
    // arithmetic shift of a signed product rounds toward minus infinity
    est = longint'(chan_estimate[ch]) + ((gain * diff) >>> 16);
    var_next = ((65536 - gain) * pred) >>> 16;
    if (var_next > 65535) var_next = 65535;
    chan_estimate[ch] = est[15:0];
    chan_variance[ch] = var_next[15:0];
    return est[15:0];
  endfunction

  function automatic logic [skf_pkg::NOISE_W-1:0] draw_noise(
      input logic [skf_pkg::NOISE_W-1:0] lowest);
    logic [skf_pkg::NOISE_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = lowest;
      1:       v = 16'hFFFF;
      2:       v = (skf_pkg::NOISE_W)'($urandom_range(int'(lowest), 2000));
      default: v = (skf_pkg::NOISE_W)'($urandom);
    endcase
    if (v < lowest) v = lowest;
    return v;
  endfunction

  // Mix of full-range values, extremes and small steps around the channel's estimate.
  function automatic logic signed [15:0] draw_sample(input logic [skf_pkg::CHAN_W-1:0] ch);
    int v;
    case ($urandom_range(0, 7))
      0:       v = -32768;
      1:       v = 32767;
      2, 3:    begin
        v = int'(chan_estimate[ch]) + int'($urandom_range(0, 64)) - 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      default: v = int'($signed(16'($urandom)));
    endcase
    return v[15:0];
  endfunction

  // Hold the sender off for a random gap unless it is steady, present one sample and wait for its transfer.
  task automatic send_sample(input logic signed [15:0] smp,
                             input logic [skf_pkg::CHAN_W-1:0] ch,
                             input logic fixed, input logic signed [15:0] fixed_est);
    int unsigned gap;
    logic signed [15:0] predicted;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    samples_if.valid   <= 1'b1;
    samples_if.sample  <= smp;
    samples_if.channel <= ch;
    do @(posedge clk_i); while (!samples_if.ready);
    predicted = kalman_update(smp, ch);
    estimate_q.push_back('{est: fixed ? fixed_est : predicted, chan: ch});
  endtask

  // Drop valid and wait until every pending estimate has come out.
  task automatic settle_block();
    samples_if.valid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skf_pkg::NOISE_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == skf_pkg::REG_PROCESS_NOISE) process_noise_q = value;
    else if (idx == skf_pkg::REG_MEAS_NOISE) meas_noise_q = value;
  endtask

  // Receive side: check each estimate transfer, then, unless the receiver is steady, stall ready for a random count.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (estimates_if.valid && estimates_if.ready) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected estimate %0d on channel %0d", $time,
                   estimates_if.estimate, estimates_if.channel_out);
          err_count++;
        end else begin
          if (estimates_if.estimate !== estimate_q[0].est) begin
            $display("%0t: estimate mismatch: expected %0d, actual %0d", $time,
                     estimate_q[0].est, estimates_if.estimate);
            err_count++;
          end
          if (estimates_if.channel_out !== estimate_q[0].chan) begin
            $display("%0t: channel mismatch: expected %0d, actual %0d", $time,
                     estimate_q[0].chan, estimates_if.channel_out);
            err_count++;
          end
          void'(estimate_q.pop_front());
        end
        hold_draw = recv_steady ? 0 : $urandom_range(0, 11);
        if (hold_draw != 0) begin
          estimates_if.ready <= 1'b0;
          ready_hold <= int'(hold_draw);
        end
      end else if (!estimates_if.ready) begin
        if (ready_hold <= 1) estimates_if.ready <= 1'b1;
        if (ready_hold > 0) ready_hold <= ready_hold - 1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((samples_if.valid && samples_if.ready) || (estimates_if.valid && estimates_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_scalar_kalman_smoother: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [skf_pkg::CHAN_W-1:0] ch;
    clk_i               = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = skf_pkg::REG_PROCESS_NOISE;
    cfg_data            = '0;
    samples_if.valid    = 1'b0;
    samples_if.sample   = '0;
    samples_if.channel  = '0;
    estimates_if.ready  = 1'b0;
    err_count           = 0;
    quiet_cycles        = 0;
    ready_hold          = 0;
    send_steady         = 1'b0;
    recv_steady         = 1'b0;
    process_noise_q     = skf_pkg::PROCESS_NOISE_RST;
    meas_noise_q        = skf_pkg::MEAS_NOISE_RST;
    foreach (chan_estimate[i]) begin
      chan_estimate[i] = '0;
      chan_variance[i] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; register writes wait for the block to go idle.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].smp, plan[i].chan, plan[i].fixed, plan[i].fixed_est);
      end
    end

    // Random phases, each under fresh noise settings and its own idling mode.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_block();
      write_reg(skf_pkg::REG_PROCESS_NOISE, draw_noise(16'd0));
      write_reg(skf_pkg::REG_MEAS_NOISE, draw_noise(16'd1));
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        ch = (skf_pkg::CHAN_W)'($urandom_range(0, skf_pkg::CHANNELS_DEF - 1));
        send_sample(draw_sample(ch), ch, 1'b0, 16'sd0);
      end
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_scalar_kalman_smoother: PASS");
    end else begin
      $display("tb_scalar_kalman_smoother: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/skf_pkg.sv
rtl/core/skf_if.sv
rtl/core/skf_store.sv
rtl/core/skf_serial.sv
rtl/core/scalar_kalman_smoother.sv
bench/tb_scalar_kalman_smoother.sv
